// File: hdl/rgb_conv3x3_clamp_core_defines.svh
// Assertion macros for the filter core's RTL files; only rcc_back includes them.
// Depends on nothing; files that check their own logic include it.
`ifndef RGB_CONV3X3_CLAMP_CORE_DEFINES_SVH
`define RGB_CONV3X3_CLAMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RCC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rcc_pkg.sv
// Shared types and constants of the RGB 3x3 convolution core.
// Depends on nothing; every module of the core refers to it by scoped names.
package rcc_pkg;

  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int KROW_W    = 24;
  localparam int NTAPS     = 9;
  localparam int NSLOTS    = 3;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 48;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam int MAX_HEIGHT      = 4096;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_COEF_BITS   = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [KROW_W-1:0] RST_KERNEL_ROW0  = 24'hFEFFFE;
  localparam logic [KROW_W-1:0] RST_KERNEL_ROW1  = 24'h0101FF;
  localparam logic [KROW_W-1:0] RST_KERNEL_ROW2  = 24'h020102;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW0  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW1  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW2  = 3'd4;

  // One classified pixel handed from the front to the back.
  // pix[3*j+i] is column c-j, row r-2+i of the window.
  // slots: bit 0 row r-2, bit 1 row r-1, bit 2 row r.
  typedef struct packed {
    logic [NTAPS-1:0][PIX_W-1:0] pix;
    logic [ROW_W-1:0]            row;
    logic [COL_W-1:0]            col;
    logic                        filt;
    logic [NSLOTS-1:0]           slots;
  } rcc_item_t;

endpackage

// File: hdl/rgb_conv3x3_clamp_core.sv
// Top level of the RGB 3x3 convolution core with clamping.
// Holds the configuration registers and joins front, queue and back.
// Depends on rcc_pkg, rcc_front, rcc_queue and rcc_back.
//
// Usage: pixels enter in raster order on the s_ channel, one beat per pixel.
// Each pixel from row 2 on yields the result for row r-2 of its column, the
// filtered value inside the frame and the pixel itself at the borders;
// a pixel of the last row also yields the pass-through pixels of rows r-1
// and r. The m_ channel carries them in that order, m_tlast on the final
// beat caused by one input pixel. Configuration is written through the
// APB port while the core is idle.
// A result beat passes the front register, the queue, the product stage and
// the output register before it is shown.
// Throughput: one pixel per cycle while the receiver takes every beat, set by
// the single line buffer read and write per pixel; a pixel of the last row
// yields up to three result beats, sent one after another.
// Reset clears counters, window, queue and output and restores the register
// defaults; the line buffers keep their contents. When the receiver stalls,
// the output holds, the queue fills and s_tready falls.
module rgb_conv3x3_clamp_core #(
  parameter int MAX_WIDTH = rcc_pkg::DEF_MAX_WIDTH,
  parameter int COEF_BITS = rcc_pkg::DEF_COEF_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rcc_pkg::IN_W-1:0]    s_tdata,   // red_in, green_in, blue_in
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rcc_pkg::OUT_W-1:0]   m_tdata,   // red_out, green_out, blue_out, out_row, out_col
  output logic                        m_tlast,   // run_last
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcc_pkg::CFG_AW-1:0]  paddr,
  input  logic [rcc_pkg::CFG_DW-1:0]  pwdata,
  output logic [rcc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  logic [rcc_pkg::FW_W-1:0]            frame_width;
  logic [rcc_pkg::FH_W-1:0]            frame_height;
  logic [2:0][rcc_pkg::KROW_W-1:0]     kernel;
  logic [rcc_pkg::REG_IDX_W-1:0]       reg_idx;
  logic                                cfg_write;

  logic                q_push, q_ready, q_valid, q_pop;
  rcc_pkg::rcc_item_t  q_in, q_out;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[rcc_pkg::CFG_AW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rcc_pkg::RST_FRAME_WIDTH;
      frame_height <= rcc_pkg::RST_FRAME_HEIGHT;
      kernel[0]    <= rcc_pkg::RST_KERNEL_ROW0;
      kernel[1]    <= rcc_pkg::RST_KERNEL_ROW1;
      kernel[2]    <= rcc_pkg::RST_KERNEL_ROW2;
    end else if (cfg_write) begin
      unique case (reg_idx)
        rcc_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[rcc_pkg::FW_W-1:0];
        rcc_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[rcc_pkg::FH_W-1:0];
        rcc_pkg::REG_KERNEL_ROW0:  kernel[0]    <= pwdata[rcc_pkg::KROW_W-1:0];
        rcc_pkg::REG_KERNEL_ROW1:  kernel[1]    <= pwdata[rcc_pkg::KROW_W-1:0];
        rcc_pkg::REG_KERNEL_ROW2:  kernel[2]    <= pwdata[rcc_pkg::KROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcc_pkg::REG_FRAME_WIDTH:  prdata = rcc_pkg::CFG_DW'(frame_width);
      rcc_pkg::REG_FRAME_HEIGHT: prdata = rcc_pkg::CFG_DW'(frame_height);
      rcc_pkg::REG_KERNEL_ROW0:  prdata = rcc_pkg::CFG_DW'(kernel[0]);
      rcc_pkg::REG_KERNEL_ROW1:  prdata = rcc_pkg::CFG_DW'(kernel[1]);
      rcc_pkg::REG_KERNEL_ROW2:  prdata = rcc_pkg::CFG_DW'(kernel[2]);
      default:                   prdata = '0;
    endcase
  end

  rcc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_push       (q_push),
    .q_item       (q_in),
    .q_ready      (q_ready)
  );

  rcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .item      (q_out),
    .pop       (q_pop)
  );

  rcc_back #(
    .COEF_BITS (COEF_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .kernel   (kernel),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hdl/rcc_front.sv
// Front end of the convolution core: raster counters, line buffers and window.
// Classifies each pixel and hands a window item to the queue. Uses rcc_pkg.
module rcc_front #(
  parameter int MAX_WIDTH = rcc_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rcc_pkg::IN_W-1:0]    s_tdata,   // red, green, blue
  input  logic [rcc_pkg::FW_W-1:0]    frame_width,
  input  logic [rcc_pkg::FH_W-1:0]    frame_height,
  output logic                        q_push,
  output rcc_pkg::rcc_item_t          q_item,
  input  logic                        q_ready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > rcc_pkg::FW_W) ? CW + 1 : rcc_pkg::FW_W;

  logic [rcc_pkg::PIX_W-1:0] line_prev1 [MAX_WIDTH];
  logic [rcc_pkg::PIX_W-1:0] line_prev2 [MAX_WIDTH];
  logic [rcc_pkg::PIX_W-1:0] rd1, rd2;

  logic [CW-1:0]             col_count;
  logic [rcc_pkg::ROW_W-1:0] row_count;
  logic [5:0][rcc_pkg::PIX_W-1:0] win;

  logic                         f_valid;
  logic [rcc_pkg::PIX_W-1:0]    f_px;
  logic [CW-1:0]                f_c;
  logic [rcc_pkg::ROW_W-1:0]    f_row;
  logic                         f_filt;
  logic [rcc_pkg::NSLOTS-1:0]   f_slots;
  logic                         f_fwd;
  logic [rcc_pkg::PIX_W-1:0]    f_fwd_top, f_fwd_mid;

  logic [WW-1:0]             fw_x;
  logic [CW-1:0]             wm1, c_cur;
  logic [rcc_pkg::ROW_W-1:0] hm1;
  logic                      last_col, last_row;
  logic                      s_accept, f_adv;
  logic [rcc_pkg::PIX_W-1:0] top_cur, mid_cur;
  logic [CW+rcc_pkg::COL_W-1:0] c_ext;

  // Effective frame limits, saturated to the supported range.
  always_comb begin
    fw_x = WW'(frame_width);
    if (fw_x == '0) begin
      wm1 = '0;
    end else if (fw_x > WW'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(fw_x - WW'(1));
    end
    if (frame_height == '0) begin
      hm1 = '0;
    end else if (frame_height > rcc_pkg::FH_W'(rcc_pkg::MAX_HEIGHT)) begin
      hm1 = rcc_pkg::ROW_W'(rcc_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = rcc_pkg::ROW_W'(frame_height - rcc_pkg::FH_W'(1));
    end
  end

  assign c_cur    = (col_count > wm1) ? wm1 : col_count;
  assign last_col = (c_cur == wm1);
  assign last_row = (row_count >= hm1);

  assign f_adv    = f_valid && ((f_slots == '0) || q_ready);
  assign s_tready = !f_valid || f_adv;
  assign s_accept = s_tvalid && s_tready;

  // A read issued in the cycle the previous pixel writes the same column sees
  // stale data, so that pixel's written values are forwarded instead.
  assign top_cur = f_fwd ? f_fwd_top : rd2;
  assign mid_cur = f_fwd ? f_fwd_mid : rd1;

  always_ff @(posedge clk) begin
    if (f_adv) begin
      line_prev2[f_c] <= mid_cur;
      line_prev1[f_c] <= f_px;
    end
    if (s_accept) begin
      rd1 <= line_prev1[c_cur];
      rd2 <= line_prev2[c_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      col_count <= '0;
      row_count <= '0;
      win       <= '0;
      f_fwd     <= 1'b0;
    end else begin
      if (s_accept) begin
        f_valid <= 1'b1;
        f_fwd   <= f_adv && (c_cur == f_c);
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + rcc_pkg::ROW_W'(1);
        end else begin
          col_count <= c_cur + CW'(1);
        end
      end else if (f_adv) begin
        f_valid <= 1'b0;
      end
      if (f_adv) begin
        win[5:3] <= win[2:0];
        win[0]   <= top_cur;
        win[1]   <= mid_cur;
        win[2]   <= f_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      f_px      <= s_tdata[rcc_pkg::PIX_W-1:0];
      f_c       <= c_cur;
      f_row     <= row_count;
      f_filt    <= !last_row && (c_cur >= CW'(3));
      f_slots   <= {last_row, last_row && (row_count != '0),
                    row_count >= rcc_pkg::ROW_W'(2)};
      f_fwd_top <= mid_cur;
      f_fwd_mid <= f_px;
    end
  end

  assign c_ext = {{rcc_pkg::COL_W{1'b0}}, f_c};

  always_comb begin
    q_item.pix   = {win[5], win[4], win[3], win[2], win[1], win[0],
                    f_px, mid_cur, top_cur};
    q_item.row   = f_row;
    q_item.col   = c_ext[rcc_pkg::COL_W-1:0];
    q_item.filt  = f_filt;
    q_item.slots = f_slots;
  end

  assign q_push = f_valid && (f_slots != '0) && q_ready;

endmodule

// File: hdl/rcc_queue.sv
// Short queue of window items between the front and back of the core.
// Uses rcc_pkg for the item type and depth.
module rcc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rcc_pkg::rcc_item_t push_item,
  output logic               ready,
  output logic               valid,
  output rcc_pkg::rcc_item_t item,
  input  logic               pop
);

  localparam int PTR_W = $clog2(rcc_pkg::QUEUE_DEPTH);

  rcc_pkg::rcc_item_t entries [rcc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;

  assign ready = (count != (PTR_W + 1)'(rcc_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: hdl/rcc_back.sv
// Back end of the convolution core: multiplies, sums and clamps each window,
// then sends one to three result beats per item. Uses rcc_pkg and the defines.
`include "rgb_conv3x3_clamp_core_defines.svh"

module rcc_back #(
  parameter int COEF_BITS = rcc_pkg::DEF_COEF_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  input  rcc_pkg::rcc_item_t                      q_item,
  output logic                                    q_pop,
  input  logic [2:0][rcc_pkg::KROW_W-1:0]         kernel,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [rcc_pkg::OUT_W-1:0]               m_tdata,
  output logic                                    m_tlast
);

  localparam int KEXT = (3 * COEF_BITS > rcc_pkg::KROW_W) ? 3 * COEF_BITS : rcc_pkg::KROW_W;
  localparam int PW   = COEF_BITS + rcc_pkg::CH_W + 1;
  localparam int SW   = PW + 4;
  localparam int PADW = rcc_pkg::OUT_W - rcc_pkg::PIX_W - rcc_pkg::ROW_W - rcc_pkg::COL_W;

  logic [2:0][KEXT-1:0]        kx;
  logic signed [COEF_BITS-1:0] coef      [rcc_pkg::NTAPS];
  logic signed [PW-1:0]        prod_next [3][rcc_pkg::NTAPS];
  logic signed [PW-1:0]        prod      [3][rcc_pkg::NTAPS];
  logic signed [SW-1:0]        sum       [3];
  logic [rcc_pkg::PIX_W-1:0]   res;

  logic                        p_valid;
  logic [rcc_pkg::PIX_W-1:0]   p_top, p_mid, p_px;
  logic [rcc_pkg::ROW_W-1:0]   p_row;
  logic [rcc_pkg::COL_W-1:0]   p_col;
  logic                        p_filt;
  logic [rcc_pkg::NSLOTS-1:0]  p_slots;

  logic [rcc_pkg::NSLOTS-1:0]  e_mask;
  logic [rcc_pkg::PIX_W-1:0]   e_pix0, e_pix1, e_pix2;
  logic [rcc_pkg::ROW_W-1:0]   e_row;
  logic [rcc_pkg::COL_W-1:0]   e_col;

  logic                        m_accept, e_single, e_load, p_take;
  logic [rcc_pkg::PIX_W-1:0]   pix_sel;
  logic [rcc_pkg::ROW_W-1:0]   row_sel;

  // Tap 3*j+i uses coefficient k[i][j]; bits above the register read as zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kx[i] = KEXT'(kernel[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[3*j+i] = kx[i][COEF_BITS*j +: COEF_BITS];
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int t = 0; t < rcc_pkg::NTAPS; t++) begin
        prod_next[ch][t] = coef[t] *
          $signed({1'b0, q_item.pix[t][rcc_pkg::CH_W*ch +: rcc_pkg::CH_W]});
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int t = 0; t < rcc_pkg::NTAPS; t++) begin
        sum[ch] = sum[ch] + SW'(prod[ch][t]);
      end
      if (sum[ch] < 0) begin
        res[rcc_pkg::CH_W*ch +: rcc_pkg::CH_W] = '0;
      end else if (sum[ch] > SW'(255)) begin
        res[rcc_pkg::CH_W*ch +: rcc_pkg::CH_W] = '1;
      end else begin
        res[rcc_pkg::CH_W*ch +: rcc_pkg::CH_W] = sum[ch][rcc_pkg::CH_W-1:0];
      end
    end
  end

  assign m_tvalid = (e_mask != '0);
  assign m_accept = m_tvalid && m_tready;
  assign e_single = (e_mask != '0) &&
                    ((e_mask & (e_mask - rcc_pkg::NSLOTS'(1))) == '0);
  assign m_tlast  = e_single;
  assign e_load   = p_valid && ((e_mask == '0) || (m_accept && e_single));
  assign p_take   = q_valid && (!p_valid || e_load);
  assign q_pop    = p_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      e_mask  <= '0;
    end else begin
      if (p_take) begin
        p_valid <= 1'b1;
      end else if (e_load) begin
        p_valid <= 1'b0;
      end
      if (e_load) begin
        e_mask <= p_slots;
      end else if (m_accept) begin
        e_mask <= e_mask & (e_mask - rcc_pkg::NSLOTS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_take) begin
      prod    <= prod_next;
      p_top   <= q_item.pix[0];
      p_mid   <= q_item.pix[1];
      p_px    <= q_item.pix[2];
      p_row   <= q_item.row;
      p_col   <= q_item.col;
      p_filt  <= q_item.filt;
      p_slots <= q_item.slots;
    end
    if (e_load) begin
      e_pix0 <= p_filt ? res : p_top;
      e_pix1 <= p_mid;
      e_pix2 <= p_px;
      e_row  <= p_row;
      e_col  <= p_col;
    end
  end

  // The lowest pending slot goes out first: the result for row r-2, then the
  // pass-through rows r-1 and r of the last input row.
  always_comb begin
    if (e_mask[0]) begin
      pix_sel = e_pix0;
      row_sel = e_row - rcc_pkg::ROW_W'(2);
    end else if (e_mask[1]) begin
      pix_sel = e_pix1;
      row_sel = e_row - rcc_pkg::ROW_W'(1);
    end else begin
      pix_sel = e_pix2;
      row_sel = e_row;
    end
  end

  assign m_tdata = {{PADW{1'b0}}, e_col, row_sel, pix_sel};

  `RCC_ASSERT_NXT(a_drain_after_last, clk, rst, m_accept && m_tlast && !e_load, !m_tvalid, "item finished but results still shown")
  `RCC_ASSERT_NXT(a_stage_holds, clk, rst, p_valid && !e_load, p_valid, "product stage lost an item")
  `RCC_ASSERT_NXT(a_slot_step, clk, rst, m_accept && !m_tlast, m_tvalid && ($countones(e_mask) == $countones($past(e_mask)) - 1), "result slots did not advance by one")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the RGB 3x3 convolution core with clamping.
// Depends on rcc_pkg and rgb_conv3x3_clamp_core; it carries its own model of the
// filter and compares every output beat with the value that model predicts.
module testbench;

  localparam int STUCK_LIMIT   = 2000;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_TARGET = 120;
  localparam int NUM_REGS      = 5;
  localparam logic [rcc_pkg::REG_IDX_W-1:0] FIRST_FREE_REG =
    rcc_pkg::REG_KERNEL_ROW2 + 1'b1;

  typedef enum {RX_FREE, RX_LIGHT, RX_HALF, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic [rcc_pkg::CH_W-1:0]  red;
    logic [rcc_pkg::CH_W-1:0]  green;
    logic [rcc_pkg::CH_W-1:0]  blue;
    logic [rcc_pkg::ROW_W-1:0] row;
    logic [rcc_pkg::COL_W-1:0] col;
    logic                      last;
  } out_pixel_t;

  // One beat of the hand-written frame; exp_px is used where typed is set.
  typedef struct packed {
    logic [rcc_pkg::PIX_W-1:0] px;
    logic                      typed;
    logic [rcc_pkg::PIX_W-1:0] exp_px;
  } dir_beat_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [rcc_pkg::IN_W-1:0]      s_tdata;   // red_in, green_in, blue_in
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rcc_pkg::OUT_W-1:0]     m_tdata;   // red_out, green_out, blue_out, out_row, out_col
  logic                          m_tlast;   // run_last
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rcc_pkg::CFG_AW-1:0]    paddr;
  logic [rcc_pkg::CFG_DW-1:0]    pwdata;
  logic [rcc_pkg::CFG_DW-1:0]    prdata;
  logic                          pready;

  // Shadow of the core's registers and state.
  logic [rcc_pkg::FW_W-1:0]   fw_q;
  logic [rcc_pkg::FH_W-1:0]   fh_q;
  logic [rcc_pkg::KROW_W-1:0] kernel_q [3];
  logic [rcc_pkg::PIX_W-1:0]  line1_q [rcc_pkg::DEF_MAX_WIDTH];
  logic [rcc_pkg::PIX_W-1:0]  line2_q [rcc_pkg::DEF_MAX_WIDTH];
  logic [rcc_pkg::PIX_W-1:0]  win_q [6];
  int                         row_q;
  int                         col_q;

  out_pixel_t pixels_due [$];
  int         mismatches = 0;
  int         burst_left = 0;
  int         random_beats = 0;
  int         hold_req_len = 0;
  int         hold_left = 0;
  int         rx_left = 0;
  rx_mode_t   rx_mode = RX_FREE;
  int         stuck = 0;

  string reg_names [NUM_REGS] = '{"frame_width", "frame_height", "kernel_row0",
                                  "kernel_row1", "kernel_row2"};

  // Width 5, height 4: row 0 red only, row 1 green and blue only. The kernel
  // gives +127 on the top row and -128 on the middle one, so red clamps high
  // and green and blue clamp low wherever the filter applies.
  dir_beat_t dir_beats [20] = '{
    '{24'h0000FF, 1'b0, 24'h000000}, '{24'h0000FF, 1'b0, 24'h000000},
    '{24'h0000FF, 1'b0, 24'h000000}, '{24'h0000FF, 1'b0, 24'h000000},
    '{24'h0000FF, 1'b0, 24'h000000},
    '{24'hFFFF00, 1'b0, 24'h000000}, '{24'hFFFF00, 1'b0, 24'h000000},
    '{24'hFFFF00, 1'b0, 24'h000000}, '{24'hFFFF00, 1'b0, 24'h000000},
    '{24'hFFFF00, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b1, 24'h0000FF}, '{24'h000000, 1'b1, 24'h0000FF},
    '{24'h017F80, 1'b1, 24'h0000FF}, '{24'hF055AA, 1'b1, 24'h0000FF},
    '{24'h80FE01, 1'b1, 24'h0000FF},
    '{24'h000000, 1'b0, 24'h000000}, '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'h01807F, 1'b0, 24'h000000}, '{24'h0F55AA, 1'b0, 24'h000000},
    '{24'hFE0180, 1'b0, 24'h000000}
  };

  rgb_conv3x3_clamp_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_pixel_t out_pixel(logic [rcc_pkg::PIX_W-1:0] px, int row, int col);
    out_pixel_t o;
    o.red   = px[7:0];
    o.green = px[15:8];
    o.blue  = px[23:16];
    o.row   = row[rcc_pkg::ROW_W-1:0];
    o.col   = col[rcc_pkg::COL_W-1:0];
    o.last  = 1'b0;
    return o;
  endfunction

  // Works out the beats caused by one accepted pixel and advances the shadow state.
  function automatic void conv_predict(logic [rcc_pkg::PIX_W-1:0] px);
    int                         w, h, c, r, n, acc;
    bit                         last_col, last_row;
    logic [rcc_pkg::PIX_W-1:0]  top, mid, fil;
    logic [rcc_pkg::PIX_W-1:0]  taps [3][3];
    logic signed [7:0]          k;
    out_pixel_t                 res [3];
    w = fw_q;
    if (w < 1) w = 1;
    if (w > rcc_pkg::DEF_MAX_WIDTH) w = rcc_pkg::DEF_MAX_WIDTH;
    h = fh_q;
    if (h < 1) h = 1;
    if (h > rcc_pkg::MAX_HEIGHT) h = rcc_pkg::MAX_HEIGHT;
    r = row_q;
    c = (col_q >= w) ? w - 1 : col_q;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    top = line2_q[c];
    mid = line1_q[c];
    // taps[j][i] is column c-j, row r-2+i.
    taps[0][0] = top;
    taps[0][1] = mid;
    taps[0][2] = px;
    for (int i = 0; i < 3; i++) begin
      taps[1][i] = win_q[i];
      taps[2][i] = win_q[3 + i];
    end
    n = 0;
    if (r >= 2) begin
      if (!last_row && c >= 3) begin
        for (int ch = 0; ch < 3; ch++) begin
          acc = 0;
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              k = kernel_q[i][8*j +: 8];
              acc += int'(k) * int'(taps[j][i][8*ch +: 8]);
            end
          end
          if (acc < 0) acc = 0;
          if (acc > 255) acc = 255;
          fil[8*ch +: 8] = acc[7:0];
        end
        res[n] = out_pixel(fil, r - 2, c);
      end else begin
        res[n] = out_pixel(top, r - 2, c);
      end
      n++;
    end
    if (last_row) begin
      if (r >= 1) begin
        res[n] = out_pixel(mid, r - 1, c);
        n++;
      end
      res[n] = out_pixel(px, r, c);
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int q = 0; q < n; q++) pixels_due = {pixels_due, res[q]};
    line2_q[c] = mid;
    line1_q[c] = px;
    for (int i = 0; i < 3; i++) begin
      win_q[3 + i] = win_q[i];
      win_q[i]     = taps[0][i];
    end
    if (last_col) begin
      col_q = 0;
      row_q = last_row ? 0 : (r + 1) % rcc_pkg::MAX_HEIGHT;
    end else begin
      col_q = c + 1;
    end
  endfunction

  function automatic logic [rcc_pkg::CFG_DW-1:0] reg_mask(
    logic [rcc_pkg::REG_IDX_W-1:0] idx
  );
    case (idx) inside
      rcc_pkg::REG_FRAME_WIDTH:  return 32'h0000_07FF;
      rcc_pkg::REG_FRAME_HEIGHT: return 32'h0000_1FFF;
      rcc_pkg::REG_KERNEL_ROW0, rcc_pkg::REG_KERNEL_ROW1, rcc_pkg::REG_KERNEL_ROW2:
        return 32'h00FF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [rcc_pkg::CFG_DW-1:0] reg_now(
    logic [rcc_pkg::REG_IDX_W-1:0] idx
  );
    case (idx)
      rcc_pkg::REG_FRAME_WIDTH:  return rcc_pkg::CFG_DW'(fw_q);
      rcc_pkg::REG_FRAME_HEIGHT: return rcc_pkg::CFG_DW'(fh_q);
      rcc_pkg::REG_KERNEL_ROW0:  return rcc_pkg::CFG_DW'(kernel_q[0]);
      rcc_pkg::REG_KERNEL_ROW1:  return rcc_pkg::CFG_DW'(kernel_q[1]);
      rcc_pkg::REG_KERNEL_ROW2:  return rcc_pkg::CFG_DW'(kernel_q[2]);
      default: return 32'h0;
    endcase
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [rcc_pkg::PIX_W-1:0] rand_pixel();
    logic [rcc_pkg::PIX_W-1:0] px;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 7))
        0: px[8*ch +: 8] = 8'h00;
        1: px[8*ch +: 8] = 8'hFF;
        default: px[8*ch +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  function automatic logic [rcc_pkg::KROW_W-1:0] rand_kernel_row();
    logic [rcc_pkg::KROW_W-1:0] kr;
    case ($urandom_range(0, 3))
      0: begin
        // Small coefficients keep most sums inside 0..255.
        for (int j = 0; j < 3; j++) kr[8*j +: 8] = 8'($urandom_range(0, 6) - 3);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: kr = 24'h000000;
          1: kr = 24'hFFFFFF;
          2: kr = 24'h7F7F7F;
          default: kr = 24'h808080;
        endcase
      end
      default: kr = rcc_pkg::KROW_W'($urandom());
    endcase
    return kr;
  endfunction

  // Bits above the register's width carry noise; the core has to drop them.
  task automatic apb_write(logic [rcc_pkg::REG_IDX_W-1:0] idx,
                           logic [rcc_pkg::CFG_DW-1:0] value);
    logic [rcc_pkg::CFG_DW-1:0] keep, word;
    keep = reg_mask(idx);
    word = (value & keep) | ($urandom() & ~keep);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx) inside
      rcc_pkg::REG_FRAME_WIDTH:  fw_q = word[rcc_pkg::FW_W-1:0];
      rcc_pkg::REG_FRAME_HEIGHT: fh_q = word[rcc_pkg::FH_W-1:0];
      rcc_pkg::REG_KERNEL_ROW0, rcc_pkg::REG_KERNEL_ROW1, rcc_pkg::REG_KERNEL_ROW2:
        kernel_q[idx - rcc_pkg::REG_KERNEL_ROW0] = word[rcc_pkg::KROW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    logic [rcc_pkg::CFG_DW-1:0] got;
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {rcc_pkg::REG_IDX_W'(i), 2'b00};
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      field_check(reg_names[i], reg_now(rcc_pkg::REG_IDX_W'(i)), got);
    end
  endtask

  task automatic set_frame(int w, int h);
    apb_write(rcc_pkg::REG_FRAME_WIDTH, w);
    apb_write(rcc_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_pixel(logic [rcc_pkg::PIX_W-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    conv_predict(px);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_empty();
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  // Also lets a row that causes no beat work its way through the core.
  task automatic settle();
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixels(int count, bit with_hold, bit with_pause);
    if (with_hold) hold_req_len = LONG_HOLD;
    for (int k = 0; k < count; k++) begin
      if (with_pause && k == count / 2) begin
        sender_idle();
        wait_empty();
      end
      send_pixel(rand_pixel());
    end
    sender_idle();
  endtask

  always @(negedge clk) begin : rx_pattern
    if (hold_req_len > 0) begin
      hold_left    = hold_req_len;
      hold_req_len = 0;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:  m_tready <= 1'b1;
        RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
        RX_HALF:  m_tready <= 1'($urandom_range(0, 1));
        default:  m_tready <= (rx_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    out_pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_due.size() == 0) begin
        $error("result beat with nothing due: row %0d col %0d",
               m_tdata[35:24], m_tdata[45:36]);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        field_check("red_out", want.red, m_tdata[7:0]);
        field_check("green_out", want.green, m_tdata[15:8]);
        field_check("blue_out", want.blue, m_tdata[23:16]);
        field_check("out_row", want.row, m_tdata[35:24]);
        field_check("out_col", want.col, m_tdata[45:36]);
        field_check("run_last", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int w, h, phase;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    fw_q        = rcc_pkg::RST_FRAME_WIDTH;
    fh_q        = rcc_pkg::RST_FRAME_HEIGHT;
    kernel_q[0] = rcc_pkg::RST_KERNEL_ROW0;
    kernel_q[1] = rcc_pkg::RST_KERNEL_ROW1;
    kernel_q[2] = rcc_pkg::RST_KERNEL_ROW2;
    foreach (line1_q[i]) begin
      line1_q[i] = '0;
      line2_q[i] = '0;
    end
    foreach (win_q[i]) win_q[i] = '0;
    row_q = 0;
    col_q = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults after reset.
    check_regs();

    // Hand-written frame with clamping at both ends.
    set_frame(5, 4);
    apb_write(rcc_pkg::REG_KERNEL_ROW0, 32'h7F7F7F);
    apb_write(rcc_pkg::REG_KERNEL_ROW1, 32'h808080);
    apb_write(rcc_pkg::REG_KERNEL_ROW2, 32'h000000);
    check_regs();
    foreach (dir_beats[k]) begin
      send_pixel(dir_beats[k].px);
      if (dir_beats[k].typed) begin
        pixels_due[pixels_due.size() - 1].red   = dir_beats[k].exp_px[7:0];
        pixels_due[pixels_due.size() - 1].green = dir_beats[k].exp_px[15:8];
        pixels_due[pixels_due.size() - 1].blue  = dir_beats[k].exp_px[23:16];
      end
    end
    sender_idle();
    settle();

    // Writes to indexes with no register behind them must change nothing.
    for (int i = int'(FIRST_FREE_REG); i < 2**rcc_pkg::REG_IDX_W; i++) begin
      apb_write(rcc_pkg::REG_IDX_W'(i), $urandom());
    end
    check_regs();

    // A long receiver hold while the sender keeps offering beats fills the
    // core; halfway through, the sender waits until every due beat is out.
    set_frame(4, 8);
    send_pixels(32, 1'b1, 1'b1);
    settle();

    // Whole frames of random size, kernel and content.
    phase = 0;
    while (random_beats < RANDOM_TARGET) begin
      case ($urandom_range(0, 7))
        0: w = 3;
        1: w = $urandom_range(13, 24);
        default: w = $urandom_range(4, 12);
      endcase
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      set_frame(w, h);
      apb_write(rcc_pkg::REG_KERNEL_ROW0, rand_kernel_row());
      apb_write(rcc_pkg::REG_KERNEL_ROW1, rand_kernel_row());
      apb_write(rcc_pkg::REG_KERNEL_ROW2, rand_kernel_row());
      check_regs();
      w = w * h * $urandom_range(1, 2);
      send_pixels(w, phase == 0, phase == 1);
      random_beats += w;
      settle();
      phase++;
    end

    // Width cut while the column counter is already past the new width.
    set_frame(8, 6);
    send_pixels(22, 1'b0, 1'b0);
    settle();
    apb_write(rcc_pkg::REG_FRAME_WIDTH, 4);
    send_pixels(13, 1'b0, 1'b0);
    settle();

    // Height cut while the row counter is already past the new height.
    set_frame(4, 8);
    send_pixels(20, 1'b0, 1'b0);
    settle();
    apb_write(rcc_pkg::REG_FRAME_HEIGHT, 3);
    send_pixels(16, 1'b0, 1'b0);
    settle();

    // Height zero saturates to a single row.
    set_frame(5, 0);
    send_pixels(5, 1'b0, 1'b0);
    settle();

    // Out-of-range widths and heights saturate instead of wrapping.
    set_frame(2047, 1);
    check_regs();
    send_pixels(24, 1'b0, 1'b0);
    settle();
    set_frame(0, 8191);
    check_regs();
    send_pixels(24, 1'b0, 1'b0);
    settle();

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/rcc_pkg.sv
hdl/rcc_front.sv
hdl/rcc_queue.sv
hdl/rcc_back.sv
hdl/rgb_conv3x3_clamp_core.sv
test/testbench.sv
